// ----- hw/rtl/spi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_pkg: shared types and constants for segment_plane_intersection
// Register indexes, datapath widths and the structs that travel along the
// pipeline.
// ----------------------------------------------------------------------------
package spi_pkg;

	localparam int CoordW = 32;
	localparam int DiffW  = 33;   // end - start, start - plane point
	localparam int DotW   = 53;   // three 18 x 33 products summed
	localparam int QuotW  = 16;   // t in Q0.16
	localparam int ProdW  = 50;   // |u| (33) times t (17)

	localparam logic [2:0] RegPlaneX = 3'd0;
	localparam logic [2:0] RegPlaneY = 3'd1;
	localparam logic [2:0] RegPlaneZ = 3'd2;
	localparam logic [2:0] RegNormX  = 3'd3;
	localparam logic [2:0] RegNormY  = 3'd4;
	localparam logic [2:0] RegNormZ  = 3'd5;
	localparam logic [2:0] RegEps    = 3'd6;

	// One restoring division step's working set
	typedef struct packed {
		logic [DotW-1:0]  den;
		logic [DotW-1:0]  rem;
		logic [QuotW-1:0] q;
	} div_t;

	// Segment data carried alongside the divider
	typedef struct packed {
		logic [2:0][CoordW-1:0] s;
		logic [2:0][DiffW-1:0]  u;
		logic                   hit;
		logic                   one;
	} carry_t;

endpackage

// ----- hw/rtl/spi_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_div_step: one bit of restoring division
// Shifts the remainder, trial-subtracts the divisor and adds one quotient bit.
// ----------------------------------------------------------------------------
module spi_div_step (
	input  spi_pkg::div_t a,
	output spi_pkg::div_t b
);
	import spi_pkg::*;

	logic [DotW:0] sh;

	// shift and trial subtract
	always_comb begin
		sh    = {a.rem, 1'b0};
		b.den = a.den;
		if (sh >= {1'b0, a.den}) begin
			b.rem = DotW'(sh - {1'b0, a.den});
			b.q   = {a.q[QuotW-2:0], 1'b1};
		end else begin
			b.rem = sh[DotW-1:0];
			b.q   = {a.q[QuotW-2:0], 1'b0};
		end
	end

endmodule

// ----- hw/rtl/segment_plane_intersection.sv -----
`timescale 1ns / 1ps
// Divider: one bit of t per stage.
// Throughput: one segment per cycle; the whole pipeline holds on output stall.
// Reset: valid bits clear; plane point and normal x/y reset to 0, normal z to
// 1.0 (65536), parallel tolerance to 7. Configuration is written whenever cfg_valid is high.
// ----------------------------------------------------------------------------
// segment_plane_intersection: segment against a configured plane
// Dot products, tolerance and range checks, pipelined Q0.16 divide and the
// cut point start + t * (end - start).
// ----------------------------------------------------------------------------
module segment_plane_intersection (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	input  logic signed [31:0] end_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic signed [31:0] cut_x,
	output logic signed [31:0] cut_y,
	output logic signed [31:0] cut_z
);
	import spi_pkg::*;

	logic signed [31:0] plane_q [3];
	logic signed [17:0] norm_q  [3];
	logic [15:0]        eps_q;

	logic en;
	logic v_s1, v_s2, v_s3, v_s5, v_s6;

	logic [CoordW-1:0]      st_in [3];
	logic [CoordW-1:0]      en_in [3];
	logic [2:0][CoordW-1:0] s_s1, s_s2, s_s3, s_s5;
	logic [2:0][DiffW-1:0]  u_s1, u_s2, u_s3, u_s5;
	logic signed [DiffW-1:0] w_s1 [3];
	logic signed [50:0]     pu_s2 [3];
	logic signed [50:0]     pw_s2 [3];
	logic signed [DotW-1:0] d_s3, n_s3;
	logic [ProdW-1:0]       prod_s5 [3];
	logic                   hit_s5;
	logic [31:0]            cut_s6 [3];
	logic                   hit_s6;

	div_t   div_s [QuotW+1];
	div_t   div_n [QuotW];
	carry_t car_s [QuotW+1];
	logic   v_d   [QuotW+1];

	assign en        = !v_s6 || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q[0] <= '0;
			plane_q[1] <= '0;
			plane_q[2] <= '0;
			norm_q[0]  <= '0;
			norm_q[1]  <= '0;
			norm_q[2]  <= 18'sd65536;
			eps_q      <= 16'd7;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegPlaneX: plane_q[0] <= cfg_data;
				RegPlaneY: plane_q[1] <= cfg_data;
				RegPlaneZ: plane_q[2] <= cfg_data;
				RegNormX:  norm_q[0]  <= cfg_data[17:0];
				RegNormY:  norm_q[1]  <= cfg_data[17:0];
				RegNormZ:  norm_q[2]  <= cfg_data[17:0];
				RegEps:    eps_q      <= cfg_data[15:0];
				default:   ;
			endcase
		end
	end

	// valid bits advance together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int k = 0; k <= QuotW; k++) v_d[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_d[0] <= v_s3;
			for (int k = 0; k < QuotW; k++) v_d[k+1] <= v_d[k];
			v_s5 <= v_d[QuotW];
			v_s6 <= v_s5;
		end
	end

	assign st_in[0] = start_x;
	assign st_in[1] = start_y;
	assign st_in[2] = start_z;
	assign en_in[0] = end_x;
	assign en_in[1] = end_y;
	assign en_in[2] = end_z;

	// stage 1: differences
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				s_s1[i] <= st_in[i];
				u_s1[i] <= {en_in[i][31], en_in[i]} - {st_in[i][31], st_in[i]};
				w_s1[i] <= $signed({st_in[i][31], st_in[i]})
					- $signed({plane_q[i][31], plane_q[i]});
			end
		end
	end

	// stage 2: products with the normal
	always_ff @(posedge clk) begin
		if (en) begin
			s_s2 <= s_s1;
			u_s2 <= u_s1;
			for (int i = 0; i < 3; i++) begin
				pu_s2[i] <= norm_q[i] * $signed(u_s1[i]);
				pw_s2[i] <= norm_q[i] * w_s1[i];
			end
		end
	end

	// stage 3: sum to d and n
	always_ff @(posedge clk) begin
		if (en) begin
			s_s3 <= s_s2;
			u_s3 <= u_s2;
			d_s3 <= DotW'(pu_s2[0]) + DotW'(pu_s2[1]) + DotW'(pu_s2[2]);
			n_s3 <= -(DotW'(pw_s2[0]) + DotW'(pw_s2[1]) + DotW'(pw_s2[2]));
		end
	end

	// stage 4: magnitudes and hit tests
	logic [DotW-1:0] ad, an;
	logic            par, neg, over;
	assign ad   = d_s3[DotW-1] ? DotW'(-d_s3) : d_s3;
	assign an   = n_s3[DotW-1] ? DotW'(-n_s3) : n_s3;
	assign par  = (d_s3 == '0) || (ad < {21'b0, eps_q, 16'b0});
	assign neg  = (n_s3 != '0) && (n_s3[DotW-1] != d_s3[DotW-1]);
	assign over = an > ad;

	always_ff @(posedge clk) begin
		if (en) begin
			car_s[0].s   <= s_s3;
			car_s[0].u   <= u_s3;
			car_s[0].hit <= !(par || neg || over);
			car_s[0].one <= an == ad;
			div_s[0].den <= ad;
			div_s[0].rem <= an;
			div_s[0].q   <= '0;
		end
	end

	// divider: one quotient bit per stage
	for (genvar k = 0; k < QuotW; k++) begin : g_div
		spi_div_step u_step (.a(div_s[k]), .b(div_n[k]));
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1] <= div_n[k];
				car_s[k+1] <= car_s[k];
			end
		end
	end

	// stage 5: t times |u|
	logic [QuotW:0] t;
	assign t = car_s[QuotW].one ? {1'b1, {QuotW{1'b0}}} : {1'b0, div_s[QuotW].q};

	always_ff @(posedge clk) begin
		if (en) begin
			s_s5   <= car_s[QuotW].s;
			u_s5   <= car_s[QuotW].u;
			hit_s5 <= car_s[QuotW].hit;
			for (int i = 0; i < 3; i++) begin
				prod_s5[i] <= (car_s[QuotW].u[i][DiffW-1]
					? DiffW'(-car_s[QuotW].u[i]) : car_s[QuotW].u[i]) * t;
			end
		end
	end

	// stage 6: floor the step and add to start
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s6 <= hit_s5;
			for (int i = 0; i < 3; i++) begin
				if (!hit_s5)
					cut_s6[i] <= '0;
				else if (!u_s5[i][DiffW-1])
					cut_s6[i] <= s_s5[i] + prod_s5[i][47:16];
				else
					cut_s6[i] <= s_s5[i] - 32'((prod_s5[i] + ProdW'(16'hFFFF)) >> 16);
			end
		end
	end

	assign out_valid = v_s6;
	assign hit       = hit_s6;
	assign cut_x     = cut_s6[0];
	assign cut_y     = cut_s6[1];
	assign cut_z     = cut_s6[2];

	// checks
	a_zero_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> cut_x == '0 && cut_y == '0 && cut_z == '0)
		else $error("cut point not zero on miss");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cut_x) && $stable(hit))
		else $error("result changed while stalled");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted beat lost at stage one");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == RegEps |=> eps_q == $past(cfg_data[15:0]))
		else $error("tolerance write not taken");

endmodule
